// ===== rtl/aabb_pkg.sv =====
// Shared constants, codes and types of the box overlap query table.
`default_nettype none

package aabb_pkg;

  localparam int NUM_SLOTS  = 32;
  localparam int COORD_BITS = 16;
  localparam int POS_W      = 16;
  localparam int SIZE_W     = 15;
  localparam int OWNER_W    = 16;
  localparam int SLOT_W     = 5;
  localparam int MAX_RES    = 32;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCAN_W = $clog2(NUM_SLOTS + 1);
  localparam int CNT_W  = $clog2(MAX_RES + 1);
  localparam int SUM_W  = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W + 1) + 1;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_POINT  = 2'd2;
  localparam logic [1:0] REQ_RECT   = 2'd3;

  localparam logic [1:0] FILT_SOLID = 2'd1;
  localparam logic [1:0] FILT_TRIG  = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [SIZE_W-1:0]            w;
    logic [SIZE_W-1:0]            h;
    logic [OWNER_W-1:0]           owner;
  } box_t;

  typedef struct packed {
    logic dying;
    logic trig;
    logic active;
    logic valid;
  } flags_t;

  typedef struct packed {
    logic match;
    logic dying;
  } test_t;

endpackage

`default_nettype wire

// ===== rtl/aabb_req_if.sv =====
// Request channel interface of the box overlap query table.
`default_nettype none

interface aabb_req_if import aabb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [SLOT_W-1:0]       slot_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [SIZE_W-1:0]       size_w;
  logic [SIZE_W-1:0]       size_h;
  logic [OWNER_W-1:0]      owner_id;
  logic                    active_in;
  logic                    trigger_in;
  logic                    dying_in;
  logic [1:0]              type_filter;
  logic                    list_mode;

  modport source (
    output valid, req_type, slot_index, pos_x, pos_y, size_w, size_h, owner_id,
           active_in, trigger_in, dying_in, type_filter, list_mode,
    input  ready
  );

  modport sink (
    input  valid, req_type, slot_index, pos_x, pos_y, size_w, size_h, owner_id,
           active_in, trigger_in, dying_in, type_filter, list_mode,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/aabb_res_if.sv =====
// Result channel interface of the box overlap query table.
`default_nettype none

interface aabb_res_if import aabb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  hit_slot;
  logic [OWNER_W-1:0] hit_owner;
  logic               last;

  modport source (
    output valid, hit, hit_slot, hit_owner, last,
    input  ready
  );

  modport sink (
    input  valid, hit, hit_slot, hit_owner, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/aabb_overlap_query_table.sv =====
// Top level of the box overlap query table: slot flags, scan sequencer and result register.
//
// Channel  Modport  Direction  Payload
// req_i    sink     in         req_type, slot_index, pos_x, pos_y, size_w, size_h,
//                              owner_id, active_in, trigger_in, dying_in, type_filter,
//                              list_mode
// res_o    source   out        hit, hit_slot, hit_owner, last
//
// A write or remove transaction completes in the cycle it is accepted.
// A query scans one slot per cycle, unless a held result stalls it, through the registered
// memory read port; an any-hit query ends right after its first match.
// Requests are not taken while a query runs; a held result stalls the scan.
// Reset clears all slot flags at once; the box memory needs no clearing.
`default_nettype none

module aabb_overlap_query_table import aabb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aabb_req_if.sink  req_i,
  aabb_res_if.source res_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_q, state_d;

  flags_t flags_q [NUM_SLOTS];
  flags_t flag_rd_q;

  logic                         req_acc;
  logic                         slot_ok;
  logic [IDX_W-1:0]             widx;
  logic                         mem_we;
  box_t                         mem_wdata;
  box_t                         mem_rdata;
  logic                         rd_en;

  logic [SCAN_W-1:0]            rd_idx_q, rd_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]             cmp_idx_q, cmp_idx_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]             pend_slot_q, pend_slot_d;
  logic [OWNER_W-1:0]           pend_owner_q, pend_owner_d;

  logic signed [COORD_BITS-1:0] qx_q, qy_q;
  logic [SIZE_W-1:0]            qw_q, qh_q;
  logic                         rect_q;
  logic [1:0]                   filt_q;
  logic                         list_q;

  logic                         out_vld_q, out_vld_d;
  logic                         out_hit_q, out_hit_d;
  logic [SLOT_W-1:0]            out_slot_q, out_slot_d;
  logic [OWNER_W-1:0]           out_owner_q, out_owner_d;
  logic                         out_last_q, out_last_d;

  test_t                        tst;
  logic                         out_free;
  logic                         push;
  logic                         stall;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign slot_ok     = int'(req_i.slot_index) < NUM_SLOTS;
  assign widx        = IDX_W'(req_i.slot_index);
  assign mem_we      = req_acc && (req_i.req_type == REQ_WRITE) && slot_ok;

  assign mem_wdata.x     = req_i.pos_x[COORD_BITS-1:0];
  assign mem_wdata.y     = req_i.pos_y[COORD_BITS-1:0];
  assign mem_wdata.w     = req_i.size_w;
  assign mem_wdata.h     = req_i.size_h;
  assign mem_wdata.owner = req_i.owner_id;

  assign out_free = !out_vld_q || res_o.ready;

  aabb_box_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (widx),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  aabb_box_test u_test (
    .box_i   (mem_rdata),
    .flags_i (flag_rd_q),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .qw_i    (qw_q),
    .qh_i    (qh_q),
    .rect_i  (rect_q),
    .filt_i  (filt_q),
    .test_o  (tst)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        flags_q[i] <= '0;
      end
    end else if (req_acc && slot_ok && (req_i.req_type == REQ_WRITE)) begin
      flags_q[widx] <= '{dying: req_i.dying_in, trig: req_i.trigger_in,
                         active: req_i.active_in, valid: 1'b1};
    end else if (req_acc && slot_ok && (req_i.req_type == REQ_REMOVE)) begin
      flags_q[widx] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      flag_rd_q <= flags_q[rd_idx_q[IDX_W-1:0]];
    end
    if (req_acc) begin
      qx_q   <= req_i.pos_x[COORD_BITS-1:0];
      qy_q   <= req_i.pos_y[COORD_BITS-1:0];
      qw_q   <= req_i.size_w;
      qh_q   <= req_i.size_h;
      rect_q <= (req_i.req_type == REQ_RECT);
      filt_q <= req_i.type_filter;
      list_q <= req_i.list_mode;
    end
  end

  always_comb begin
    state_d      = state_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    cnt_d        = cnt_q;
    pend_vld_d   = pend_vld_q;
    pend_slot_d  = pend_slot_q;
    pend_owner_d = pend_owner_q;
    out_vld_d    = out_vld_q && !res_o.ready;
    out_hit_d    = out_hit_q;
    out_slot_d   = out_slot_q;
    out_owner_d  = out_owner_q;
    out_last_d   = out_last_q;
    push         = 1'b0;
    stall        = 1'b0;
    rd_en        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc && ((req_i.req_type == REQ_POINT) || (req_i.req_type == REQ_RECT))) begin
          state_d    = ST_SCAN;
          rd_idx_d   = '0;
          cmp_vld_d  = 1'b0;
          cnt_d      = '0;
          pend_vld_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (cmp_vld_q && tst.match && !list_q) begin
          push        = 1'b1;
          out_hit_d   = 1'b1;
          out_slot_d  = SLOT_W'(cmp_idx_q);
          out_owner_d = mem_rdata.owner;
          out_last_d  = 1'b1;
        end else if (cmp_vld_q && tst.match && !tst.dying && pend_vld_q) begin
          push        = 1'b1;
          out_hit_d   = 1'b1;
          out_slot_d  = SLOT_W'(pend_slot_q);
          out_owner_d = pend_owner_q;
          out_last_d  = 1'b0;
        end
        stall = push && !out_free;
        if (!stall) begin
          if (push) begin
            out_vld_d = 1'b1;
          end
          if (cmp_vld_q && tst.match && !list_q) begin
            state_d   = ST_IDLE;
            cmp_vld_d = 1'b0;
          end else if (cmp_vld_q && tst.match && !tst.dying
                       && (cnt_q == CNT_W'(MAX_RES - 1))) begin
            pend_vld_d   = 1'b1;
            pend_slot_d  = cmp_idx_q;
            pend_owner_d = mem_rdata.owner;
            cnt_d        = cnt_q + CNT_W'(1);
            state_d      = ST_FLUSH;
            cmp_vld_d    = 1'b0;
          end else begin
            if (cmp_vld_q && tst.match && !tst.dying) begin
              pend_vld_d   = 1'b1;
              pend_slot_d  = cmp_idx_q;
              pend_owner_d = mem_rdata.owner;
              cnt_d        = cnt_q + CNT_W'(1);
            end
            if (int'(rd_idx_q) < NUM_SLOTS) begin
              rd_en     = 1'b1;
              cmp_vld_d = 1'b1;
              cmp_idx_d = rd_idx_q[IDX_W-1:0];
              rd_idx_d  = rd_idx_q + SCAN_W'(1);
            end else begin
              cmp_vld_d = 1'b0;
              if (!cmp_vld_q) begin
                state_d = ST_FLUSH;
              end
            end
          end
        end
      end
      ST_FLUSH: begin
        push = 1'b1;
        if (list_q && pend_vld_q) begin
          out_hit_d   = 1'b1;
          out_slot_d  = SLOT_W'(pend_slot_q);
          out_owner_d = pend_owner_q;
        end else begin
          out_hit_d   = 1'b0;
          out_slot_d  = '0;
          out_owner_d = '0;
        end
        out_last_d = 1'b1;
        stall      = !out_free;
        if (!stall) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (stall) begin
      out_hit_d   = out_hit_q;
      out_slot_d  = out_slot_q;
      out_owner_d = out_owner_q;
      out_last_d  = out_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    pend_slot_q  <= pend_slot_d;
    pend_owner_q <= pend_owner_d;
    out_hit_q    <= out_hit_d;
    out_slot_q   <= out_slot_d;
    out_owner_q  <= out_owner_d;
    out_last_q   <= out_last_d;
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.hit       = out_hit_q;
  assign res_o.hit_slot  = out_slot_q;
  assign res_o.hit_owner = out_owner_q;
  assign res_o.last      = out_last_q;

  a_pend_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (cnt_q != '0))
    else $error("Pending hit without a hit count.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= MAX_RES)
    else $error("Hit count exceeds the list limit.");

  a_stall_holds_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && stall) |=> $stable(rd_idx_q))
    else $error("Scan address moved during a result stall.");

  a_idle_no_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cmp_vld_q)
    else $error("Compare stage busy while idle.");

endmodule

`default_nettype wire

// ===== rtl/aabb_box_ram.sv =====
// Box storage memory with one write port and one registered read port.
`default_nettype none

module aabb_box_ram import aabb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire box_t             wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output box_t                  rdata_o
);

  box_t mem [NUM_SLOTS];
  box_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/aabb_box_test.sv =====
// Shared overlap test unit: usability filter plus point or rect compare of one box.
`default_nettype none

module aabb_box_test import aabb_pkg::*; (
  input  wire box_t                         box_i,
  input  wire flags_t                       flags_i,
  input  wire logic signed [COORD_BITS-1:0] qx_i,
  input  wire logic signed [COORD_BITS-1:0] qy_i,
  input  wire logic [SIZE_W-1:0]            qw_i,
  input  wire logic [SIZE_W-1:0]            qh_i,
  input  wire logic                         rect_i,
  input  wire logic [1:0]                   filt_i,
  output test_t                             test_o
);

  logic signed [SUM_W-1:0] bx, by, bx_end, by_end;
  logic signed [SUM_W-1:0] qx, qy, qx_end, qy_end;
  logic                    usable;
  logic                    geo;

  always_comb begin
    bx     = SUM_W'(box_i.x);
    by     = SUM_W'(box_i.y);
    bx_end = bx + SUM_W'($signed({1'b0, box_i.w}));
    by_end = by + SUM_W'($signed({1'b0, box_i.h}));
    qx     = SUM_W'(qx_i);
    qy     = SUM_W'(qy_i);
    qx_end = qx + SUM_W'($signed({1'b0, qw_i}));
    qy_end = qy + SUM_W'($signed({1'b0, qh_i}));

    usable = flags_i.valid && flags_i.active
             && !(flags_i.trig && (filt_i == FILT_SOLID))
             && !(!flags_i.trig && (filt_i == FILT_TRIG));

    if (rect_i) begin
      geo = (qx < bx_end) && (qx_end > bx) && (qy < by_end) && (qy_end > by);
    end else begin
      geo = (qx >= bx) && (qx <= bx_end) && (qy >= by) && (qy <= by_end);
    end

    test_o.match = usable && geo;
    test_o.dying = flags_i.dying;
  end

endmodule

`default_nettype wire
